/* rtl/core/gfws_pkg.sv */
`default_nettype none
package gfws_pkg;

    localparam int DATA_W   = 32;
    localparam int COEF_W   = 18;
    localparam int OPER_W   = 33;
    localparam int PROD_W   = 2 * OPER_W;
    localparam int FRAC_W   = 16;
    localparam int WIDE_W   = PROD_W - FRAC_W;
    localparam int ACC_W    = 40;
    localparam int NUM_REGS = 6;
    localparam int ADDR_W   = 5;
    localparam int PDATA_W  = 32;

    localparam logic signed [DATA_W-1:0] IMPULSE = 32'sd65536000;

    localparam logic [1:0] FUNC_STEP   = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_REINIT = 2'd2;

    localparam logic [2:0] REG_LOCAL_KEEP     = 3'd0;
    localparam logic [2:0] REG_LOCAL_SPRING   = 3'd1;
    localparam logic [2:0] REG_LOCAL_FRICTION = 3'd2;
    localparam logic [2:0] REG_LINK_KEEP      = 3'd3;
    localparam logic [2:0] REG_LINK_ACCEL     = 3'd4;
    localparam logic [2:0] REG_LINK_FRICTION  = 3'd5;

    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] cell_index;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] quantity;
        logic signed [31:0] change;
        logic               saturated;
    } t_result;

    typedef struct packed {
        logic signed [COEF_W-1:0] local_keep;
        logic signed [COEF_W-1:0] local_spring;
        logic signed [COEF_W-1:0] local_friction;
        logic signed [COEF_W-1:0] link_keep;
        logic signed [COEF_W-1:0] link_accel;
        logic signed [COEF_W-1:0] link_friction;
    } t_cfg;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] acc_op;
    } t_mac_ctl;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [WIDE_W-1:0] v);
        t_sat r;
        if (v > WIDE_W'(64'sh7FFFFFFF)) begin
            r.hit = 1'b1;
            r.val = 32'sh7FFFFFFF;
        end else if (v < -WIDE_W'(64'sh80000000)) begin
            r.hit = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.hit = 1'b0;
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/gfws_cfg.sv */
`default_nettype none
module gfws_cfg
    import gfws_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    logic [2:0] w_reg;
    logic signed [COEF_W-1:0] w_rd;

    assign w_reg  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_keep     <= 18'sd65536;
            r_cfg.local_spring   <= '0;
            r_cfg.local_friction <= '0;
            r_cfg.link_keep      <= 18'sd65536;
            r_cfg.link_accel     <= 18'sd6554;
            r_cfg.link_friction  <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_LOCAL_KEEP:     r_cfg.local_keep     <= pwdata[COEF_W-1:0];
                REG_LOCAL_SPRING:   r_cfg.local_spring   <= pwdata[COEF_W-1:0];
                REG_LOCAL_FRICTION: r_cfg.local_friction <= pwdata[COEF_W-1:0];
                REG_LINK_KEEP:      r_cfg.link_keep      <= pwdata[COEF_W-1:0];
                REG_LINK_ACCEL:     r_cfg.link_accel     <= pwdata[COEF_W-1:0];
                REG_LINK_FRICTION:  r_cfg.link_friction  <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_LOCAL_KEEP:     w_rd = r_cfg.local_keep;
            REG_LOCAL_SPRING:   w_rd = r_cfg.local_spring;
            REG_LOCAL_FRICTION: w_rd = r_cfg.local_friction;
            REG_LINK_KEEP:      w_rd = r_cfg.link_keep;
            REG_LINK_ACCEL:     w_rd = r_cfg.link_accel;
            REG_LINK_FRICTION:  w_rd = r_cfg.link_friction;
            default:            w_rd = '0;
        endcase
        prdata = {{(PDATA_W-COEF_W){w_rd[COEF_W-1]}}, w_rd};
    end

endmodule
`default_nettype wire

/* rtl/core/gfws_mac.sv */
`default_nettype none
module gfws_mac
    import gfws_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [OPER_W-1:0] i_a,
    input  wire logic signed [OPER_W-1:0] i_b,
    output logic signed [WIDE_W-1:0]      o_prod_q,
    output logic signed [ACC_W-1:0]       o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_term;

    assign o_prod_q = r_prod[PROD_W-1:FRAC_W];
    assign w_term   = o_prod_q[ACC_W-1:0];
    assign o_acc    = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= w_term;
            ACC_ADD:  r_acc <= r_acc + w_term;
            ACC_SUB:  r_acc <= r_acc - w_term;
            default:  r_acc <= r_acc;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/grid_flow_wave_step_unit.sv */
`default_nettype none
// Step: 5 flows per inner cell (the local flow and its links; edge cells skip
//   missing links), all computed on the one shared 33x33 multiplier.
// Reinitialize: one memory row per cycle.
// One command at a time; busy stays high until the result beat, which the
// receiver cannot stall. Reset runs a clearing pass with busy high.
module grid_flow_wave_step_unit
    import gfws_pkg::*;
#(
    parameter int GRID_SIDE = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_cmd               i_cmd,
    output logic                    o_valid,
    output t_result                 o_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W = $clog2(CELLS);
    localparam int SIDE_W = $clog2(GRID_SIDE);
    localparam int CENTER = (CELLS + GRID_SIDE) / 2;
    localparam int ROW_W  = 6 * DATA_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_RDW  = 4'd3;
    localparam logic [3:0] ST_LD   = 4'd4;
    localparam logic [3:0] ST_LW   = 4'd5;
    localparam logic [3:0] ST_FLOW = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    t_cfg w_cfg;

    gfws_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (w_cfg)
    );

    logic [DATA_W-1:0] q_mem   [CELLS];
    logic [ROW_W-1:0]  row_mem [CELLS];

    logic [3:0]               r_state;
    logic [CELL_W-1:0]        r_cell;
    logic [SIDE_W-1:0]        r_row;
    logic [SIDE_W-1:0]        r_col;
    logic [CELL_W-1:0]        r_idx;
    logic                     r_idx_ok;
    logic                     r_clr_out;
    logic [2:0]               r_k;
    logic [2:0]               r_ph;
    logic                     r_sat;
    logic signed [DATA_W-1:0] r_q;
    logic signed [DATA_W-1:0] r_qrd;
    logic [ROW_W-1:0]         r_rowrd;
    logic signed [DATA_W-1:0] r_flow [5];
    logic signed [DATA_W-1:0] r_s;
    logic signed [ACC_W-1:0]  r_qacc;
    logic                     r_valid;
    t_result                  r_result;

    logic [CELL_W-1:0]        w_qaddr;
    logic [CELL_W-1:0]        w_raddr;
    logic [CELL_W-1:0]        w_nb;
    logic                     w_missing;
    logic                     w_is_link;
    logic signed [DATA_W-1:0] w_x;
    logic signed [COEF_W-1:0] w_keep;
    logic signed [COEF_W-1:0] w_fric;
    logic signed [COEF_W-1:0] w_coef;
    t_mac_ctl                 w_ctl;
    logic signed [OPER_W-1:0] w_a;
    logic signed [OPER_W-1:0] w_b;
    logic signed [WIDE_W-1:0] w_prod_q;
    logic signed [ACC_W-1:0]  w_acc;
    t_sat                     w_s_sat;
    t_sat                     w_nx;
    t_sat                     w_nq;
    t_sat                     w_ch;
    logic signed [DATA_W:0]   w_diff;
    logic [ROW_W-1:0]         w_row_new;
    logic                     w_last;

    gfws_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_prod_q(w_prod_q),
        .o_acc   (w_acc)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign w_is_link = (r_k != 3'd0);
    assign w_last    = (r_cell == CELL_W'(CELLS - 1));

    always_comb begin
        case (r_k)
            3'd1: begin
                w_nb      = r_cell - CELL_W'(GRID_SIDE);
                w_missing = (r_row == '0);
            end
            3'd2: begin
                w_nb      = r_cell + CELL_W'(1);
                w_missing = (r_col == SIDE_W'(GRID_SIDE - 1));
            end
            3'd3: begin
                w_nb      = r_cell + CELL_W'(GRID_SIDE);
                w_missing = (r_row == SIDE_W'(GRID_SIDE - 1));
            end
            3'd4: begin
                w_nb      = r_cell - CELL_W'(1);
                w_missing = (r_col == '0);
            end
            default: begin
                w_nb      = r_cell;
                w_missing = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            ST_RD, ST_RDW: w_qaddr = r_idx;
            ST_FLOW:       w_qaddr = w_nb;
            default:       w_qaddr = r_cell;
        endcase
        w_raddr = (r_state == ST_RD || r_state == ST_RDW) ? r_idx : r_cell;
    end

    always_comb begin
        w_x    = r_flow[r_k];
        w_keep = w_is_link ? w_cfg.link_keep : w_cfg.local_keep;
        w_fric = w_is_link ? w_cfg.link_friction : w_cfg.local_friction;
        w_coef = w_is_link ? w_cfg.link_accel : w_cfg.local_spring;
        w_diff = {r_qrd[DATA_W-1], r_qrd} - {r_q[DATA_W-1], r_q};
        w_ctl  = '{mul_en: 1'b0, acc_op: ACC_HOLD};
        w_a    = {w_x[DATA_W-1], w_x};
        w_b    = {{(OPER_W-COEF_W){w_keep[COEF_W-1]}}, w_keep};
        if (r_state == ST_FLOW) begin
            case (r_ph)
                3'd1: w_ctl.mul_en = 1'b1;
                3'd2: begin
                    w_ctl = '{mul_en: 1'b1, acc_op: ACC_LOAD};
                    w_b   = {w_x[DATA_W-1], w_x};
                end
                3'd4: begin
                    w_ctl.mul_en = 1'b1;
                    w_a = {r_s[DATA_W-1], r_s};
                    w_b = {{(OPER_W-COEF_W){w_fric[COEF_W-1]}}, w_fric};
                end
                3'd5: begin
                    w_ctl = '{mul_en: 1'b1,
                              acc_op: (w_x > 0) ? ACC_SUB : ACC_ADD};
                    w_a = w_is_link ? w_diff : {r_q[DATA_W-1], r_q};
                    w_b = {{(OPER_W-COEF_W){w_coef[COEF_W-1]}}, w_coef};
                end
                3'd6: w_ctl.acc_op = w_is_link ? ACC_ADD : ACC_SUB;
                default: ;
            endcase
        end
    end

    assign w_s_sat = sat32(w_prod_q);
    assign w_nx    = sat32({{(WIDE_W-ACC_W){w_acc[ACC_W-1]}}, w_acc});
    assign w_nq    = sat32({{(WIDE_W-ACC_W){r_qacc[ACC_W-1]}}, r_qacc});
    assign w_ch    = sat32(WIDE_W'(signed'({w_nq.val[DATA_W-1], w_nq.val})
                                   - signed'({r_q[DATA_W-1], r_q})));
    assign w_row_new = {w_ch.val, r_flow[4], r_flow[3], r_flow[2], r_flow[1], r_flow[0]};

    always_ff @(posedge i_clk) begin
        r_qrd   <= q_mem[w_qaddr];
        r_rowrd <= row_mem[w_raddr];
        if (r_state == ST_CLR) begin
            q_mem[r_cell]   <= (r_cell == CELL_W'(CENTER)) ? IMPULSE : '0;
            row_mem[r_cell] <= '0;
        end else if (r_state == ST_FIN) begin
            q_mem[r_cell]   <= w_nq.val;
            row_mem[r_cell] <= w_row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_cell    <= '0;
            r_clr_out <= 1'b0;
            r_sat     <= 1'b0;
            r_valid   <= 1'b0;
            r_k       <= '0;
            r_ph      <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_cell <= '0;
                        r_row  <= '0;
                        r_col  <= '0;
                        r_idx  <= CELL_W'(i_cmd.cell_index);
                        r_idx_ok <= (int'(i_cmd.cell_index) < CELLS);
                        case (i_cmd.func)
                            FUNC_STEP: begin
                                r_sat   <= 1'b0;
                                r_state <= ST_LD;
                            end
                            FUNC_READ: r_state <= ST_RD;
                            FUNC_REINIT: begin
                                r_sat     <= 1'b0;
                                r_clr_out <= 1'b1;
                                r_state   <= ST_CLR;
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_CLR: begin
                    r_cell <= r_cell + CELL_W'(1);
                    if (w_last) begin
                        r_clr_out <= 1'b0;
                        r_state   <= r_clr_out ? ST_DONE : ST_IDLE;
                    end
                end
                ST_RD: r_state <= ST_RDW;
                ST_RDW: begin
                    r_valid            <= 1'b1;
                    r_result.quantity  <= r_idx_ok ? r_qrd : '0;
                    r_result.change    <= r_idx_ok ? r_rowrd[ROW_W-1 -: DATA_W] : '0;
                    r_result.saturated <= r_sat;
                    r_state            <= ST_IDLE;
                end
                ST_LD: r_state <= ST_LW;
                ST_LW: begin
                    r_q    <= r_qrd;
                    r_qacc <= {{(ACC_W-DATA_W){r_qrd[DATA_W-1]}}, r_qrd};
                    for (int n = 0; n < 5; n++) begin
                        r_flow[n] <= r_rowrd[n*DATA_W +: DATA_W];
                    end
                    r_k     <= '0;
                    r_ph    <= '0;
                    r_state <= ST_FLOW;
                end
                ST_FLOW: begin
                    case (r_ph)
                        3'd0: begin
                            if (w_is_link && w_missing) begin
                                if (r_k == 3'd4) begin
                                    r_state <= ST_FIN;
                                end
                                r_k <= r_k + 3'd1;
                            end else begin
                                r_ph <= 3'd1;
                            end
                        end
                        3'd3: begin
                            r_s   <= w_s_sat.val;
                            r_sat <= r_sat | w_s_sat.hit;
                            r_ph  <= 3'd4;
                        end
                        3'd7: begin
                            r_flow[r_k] <= w_nx.val;
                            r_qacc <= r_qacc + {{(ACC_W-DATA_W){w_nx.val[DATA_W-1]}}, w_nx.val};
                            r_sat  <= r_sat | w_nx.hit;
                            r_ph   <= 3'd0;
                            r_k    <= r_k + 3'd1;
                            if (r_k == 3'd4) begin
                                r_state <= ST_FIN;
                            end
                        end
                        default: r_ph <= r_ph + 3'd1;
                    endcase
                end
                ST_FIN: begin
                    r_sat <= r_sat | w_nq.hit | w_ch.hit;
                    if (w_last) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cell <= r_cell + CELL_W'(1);
                        if (r_col == SIDE_W'(GRID_SIDE - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + SIDE_W'(1);
                        end else begin
                            r_col <= r_col + SIDE_W'(1);
                        end
                        r_state <= ST_LD;
                    end
                end
                ST_DONE: begin
                    r_valid            <= 1'b1;
                    r_result.quantity  <= '0;
                    r_result.change    <= '0;
                    r_result.saturated <= r_sat;
                    r_state            <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/gfws_chk.sv */
`default_nettype none
module gfws_chk
    import gfws_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_valid,
    input wire t_result o_result
);

    a_beat_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat longer than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    a_stay_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> (!busy && !o_valid))
        else $error("activity without a command");

endmodule

bind grid_flow_wave_step_unit gfws_chk u_gfws_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_result(o_result)
);
`default_nettype wire

/* verif/grid_flow_wave_step_unit_tb.sv */
`timescale 1ns / 100ps
module grid_flow_wave_step_unit_tb;
    import gfws_pkg::*;

    localparam int SIDE     = 16;
    localparam int NCELLS   = SIDE * SIDE;
    localparam int CENTER   = (SIDE * SIDE + SIDE) / 2;
    localparam int WD_LIMIT = 60000;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_cmd                i_cmd;
    logic                o_valid;
    t_result             o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    grid_flow_wave_step_unit #(.GRID_SIDE(SIDE)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_valid(o_valid), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    longint  grid_qty [NCELLS];
    longint  grid_lflow [NCELLS];
    longint  grid_link [NCELLS*4];
    longint  grid_chg [NCELLS];
    bit      grid_sat;
    longint  coef [NUM_REGS];
    t_result expected_results [$];
    int      error_count;
    int      idle_pct;
    int      quiet_cycles;

    function automatic longint clamp32(longint v);
        if (v > QMAX) begin
            grid_sat = 1'b1;
            return QMAX;
        end
        if (v < QMIN) begin
            grid_sat = 1'b1;
            return QMIN;
        end
        return v;
    endfunction

    function automatic longint mul_q16(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint friction_of(longint f, longint k);
        longint s;
        longint t;
        s = clamp32(mul_q16(f, f));
        t = mul_q16(s, k);
        return (f > 0) ? -t : t;
    endfunction

    function automatic void grid_clear();
        for (int i = 0; i < NCELLS; i++) begin
            grid_qty[i] = 0;
            grid_lflow[i] = 0;
            grid_chg[i] = 0;
        end
        for (int i = 0; i < NCELLS * 4; i++) grid_link[i] = 0;
        grid_qty[CENTER] = longint'(IMPULSE);
        grid_sat = 1'b0;
    endfunction

    function automatic void grid_step();
        longint q;
        longint nf;
        longint acc;
        longint nq;
        longint nl;
        int     row;
        int     col;
        int     nb;
        grid_sat = 1'b0;
        for (int i = 0; i < NCELLS; i++) begin
            row = i / SIDE;
            col = i % SIDE;
            q = grid_qty[i];
            nf = clamp32(mul_q16(grid_lflow[i], coef[REG_LOCAL_KEEP])
                         - mul_q16(q, coef[REG_LOCAL_SPRING])
                         + friction_of(grid_lflow[i], coef[REG_LOCAL_FRICTION]));
            grid_lflow[i] = nf;
            acc = q + nf;
            for (int j = 0; j < 4; j++) begin
                case (j)
                    0: nb = (row == 0) ? -1 : i - SIDE;
                    1: nb = (col == SIDE - 1) ? -1 : i + 1;
                    2: nb = (row == SIDE - 1) ? -1 : i + SIDE;
                    default: nb = (col == 0) ? -1 : i - 1;
                endcase
                if (nb >= 0) begin
                    nl = clamp32(mul_q16(grid_link[i*4+j], coef[REG_LINK_KEEP])
                                 + mul_q16(grid_qty[nb] - q, coef[REG_LINK_ACCEL])
                                 + friction_of(grid_link[i*4+j], coef[REG_LINK_FRICTION]));
                    grid_link[i*4+j] = nl;
                    acc += nl;
                end
            end
            nq = clamp32(acc);
            grid_chg[i] = clamp32(nq - q);
            grid_qty[i] = nq;
        end
    endfunction

    function automatic t_result grid_apply(t_cmd c);
        t_result r;
        r = '0;
        case (c.func)
            FUNC_STEP: grid_step();
            FUNC_READ: begin
                r.quantity = grid_qty[c.cell_index][31:0];
                r.change = grid_chg[c.cell_index][31:0];
            end
            FUNC_REINIT: grid_clear();
            default: ;
        endcase
        r.saturated = grid_sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, o_result);
                error_count++;
            end else begin
                t_result e;
                e = expected_results.pop_front();
                if (e.quantity !== o_result.quantity) begin
                    $display("%0t: quantity expected %h actual %h",
                             $time, e.quantity, o_result.quantity);
                    error_count++;
                end
                if (e.change !== o_result.change) begin
                    $display("%0t: change expected %h actual %h",
                             $time, e.change, o_result.change);
                    error_count++;
                end
                if (e.saturated !== o_result.saturated) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, e.saturated, o_result.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_cmd(logic [1:0] func, logic [7:0] idx);
        bit taken;
        t_cmd c;
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        c.func = func;
        c.cell_index = idx;
        start = 1'b1;
        i_cmd = c;
        taken = 1'b0;
        while (!taken) begin
            taken = !busy;
            @(posedge i_clk);
            if (taken) expected_results.push_back(grid_apply(c));
            @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (expected_results.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'({idx, 2'b00});
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        coef[idx] = longint'(signed'(data[COEF_W-1:0]));
    endtask

    task automatic set_all_coefs(logic [31:0] v);
        drain();
        for (int i = 0; i < NUM_REGS; i++) write_reg(3'(i), v);
    endtask

    task automatic run_mix(int count);
        int    sel;
        logic [1:0] f;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 12) f = FUNC_STEP;
            else if (sel < 20) f = FUNC_REINIT;
            else if (sel < 25) f = 2'd3;
            else f = FUNC_READ;
            send_cmd(f, 8'($urandom));
        end
    endtask

    task automatic test_reset_state();
        send_cmd(FUNC_READ, 8'(CENTER));
        send_cmd(FUNC_READ, 8'd0);
        send_cmd(FUNC_READ, 8'd255);
        send_cmd(2'd3, 8'hFF);
    endtask

    task automatic test_directed();
        send_cmd(FUNC_STEP, 8'h00);
        send_cmd(FUNC_READ, 8'(CENTER));
        send_cmd(FUNC_READ, 8'(CENTER - 1));
        send_cmd(FUNC_READ, 8'(CENTER + SIDE));
        send_cmd(FUNC_STEP, 8'hFF);
        send_cmd(FUNC_READ, 8'(CENTER - SIDE));
        send_cmd(FUNC_READ, 8'd15);
        send_cmd(FUNC_READ, 8'd240);
        send_cmd(FUNC_REINIT, 8'hAA);
        send_cmd(FUNC_READ, 8'(CENTER));
        send_cmd(2'd3, 8'h55);
    endtask

    task automatic test_extremes();
        set_all_coefs(32'h0001_FFFF);
        send_cmd(FUNC_STEP, 8'h00);
        send_cmd(FUNC_STEP, 8'h00);
        send_cmd(FUNC_READ, 8'(CENTER));
        send_cmd(FUNC_READ, 8'(CENTER + 1));
        send_cmd(FUNC_REINIT, 8'h00);
        set_all_coefs(32'hFFFE_0000);
        send_cmd(FUNC_STEP, 8'h00);
        send_cmd(FUNC_STEP, 8'h00);
        send_cmd(FUNC_READ, 8'(CENTER));
        send_cmd(FUNC_READ, 8'(CENTER - SIDE));
        send_cmd(FUNC_READ, 8'd0);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++) begin
            drain();
            for (int i = 0; i < NUM_REGS; i++) write_reg(3'(i), $urandom);
            idle_pct = (phase == 2) ? 0 : 27;
            send_cmd(FUNC_REINIT, 8'($urandom));
            run_mix(62);
        end
        drain();
        write_reg(REG_LOCAL_KEEP, 32'h0001_0000);
        write_reg(REG_LOCAL_SPRING, 32'h0000_0800);
        write_reg(REG_LOCAL_FRICTION, 32'h0000_0010);
        write_reg(REG_LINK_KEEP, 32'h0000_F000);
        write_reg(REG_LINK_ACCEL, 32'h0000_199A);
        write_reg(REG_LINK_FRICTION, 32'h0000_0010);
        idle_pct = 27;
        run_mix(20);
    endtask

    initial begin
        error_count = 0;
        idle_pct = 27;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        coef[REG_LOCAL_KEEP] = 65536;
        coef[REG_LOCAL_SPRING] = 0;
        coef[REG_LOCAL_FRICTION] = 0;
        coef[REG_LINK_KEEP] = 65536;
        coef[REG_LINK_ACCEL] = 6554;
        coef[REG_LINK_FRICTION] = 0;
        grid_clear();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_directed();
        test_extremes();
        test_random();
        drain();
        repeat (50) @(negedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
